FILE: hw/rtl/cbc_pkg.sv
// shared types, widths and constants of the cascaded balance controller
package cbc_pkg;

  localparam int FILTER_SHIFT_DEF = 7;

  // working width of the datapath and the divider dividend
  localparam int DVD_W = 58;
  // divisor width, holds the largest divisor 128000000
  localparam int DVS_W = 27;
  // product width: 34-bit signed operand times 17-bit signed gain
  localparam int MA_W  = 34;
  localparam int MB_W  = 17;
  localparam int P_W   = MA_W + MB_W;
  // torque accumulator and scaled torque width
  localparam int ACC_W = 44;

  typedef logic signed [DVD_W-1:0] wide_t;

  typedef enum logic [2:0] {
    CFG_SPEED_I_GAIN      = 3'd0,
    CFG_SPEED_P_GAIN      = 3'd1,
    CFG_PITCH_P_GAIN      = 3'd2,
    CFG_PITCH_D_GAIN      = 3'd3,
    CFG_PITCH_TRIM        = 3'd4,
    CFG_ROLL_SPEED_I_GAIN = 3'd5,
    CFG_ROLL_P_GAIN       = 3'd6,
    CFG_ROLL_TRIM         = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] RST_SPEED_I_GAIN      = 16'd205;
  localparam logic [15:0] RST_SPEED_P_GAIN      = 16'd2560;
  localparam logic [15:0] RST_PITCH_P_GAIN      = 16'd512;
  localparam logic [15:0] RST_PITCH_D_GAIN      = 16'd256;
  localparam logic [15:0] RST_PITCH_TRIM        = 16'd1408;
  localparam logic [15:0] RST_ROLL_SPEED_I_GAIN = 16'd5120;
  localparam logic [15:0] RST_ROLL_P_GAIN       = 16'd768;
  localparam logic [15:0] RST_ROLL_TRIM         = 16'hFC4D; // -947

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_CMD,
    OP_RAMP,
    OP_MUL_SI,
    OP_DIV_SI,
    OP_PINT,
    OP_DIV_SP,
    OP_PE,
    OP_MUL_PP,
    OP_T1A,
    OP_T1B,
    OP_DIV_FD,
    OP_DIV_SCN,
    OP_T1_SAVE,
    OP_MUL_RI,
    OP_DIV_RI,
    OP_RINT,
    OP_DIV_R20,
    OP_RE,
    OP_MUL_RP,
    OP_T2A,
    OP_DIV_RD,
    OP_T2B,
    OP_DIV_FR,
    OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CMD,
    S_RAMP,
    S_MUL_SI,
    S_DIV_SI,
    S_PINT,
    S_DIV_SP,
    S_PE,
    S_MUL_PP,
    S_T1A,
    S_T1B,
    S_DIV_FD,
    S_SCN1,
    S_T1_SAVE,
    S_MUL_RI,
    S_DIV_RI,
    S_RINT,
    S_DIV_R20,
    S_RE,
    S_MUL_RP,
    S_T2A,
    S_DIV_RD,
    S_T2B,
    S_DIV_FR,
    S_SCN2,
    S_FIN,
    S_WAIT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

FILE: hw/rtl/cbc_div.sv
// shared signed divider, two quotient bits per cycle, truncates toward zero
module cbc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  cbc_pkg::wide_t             dividend,
  input  logic [cbc_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output cbc_pkg::wide_t             quotient
);
  import cbc_pkg::*;

  localparam int STEPS = DVD_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DVD_W-1:0] n, n_next;
  logic [DVS_W-1:0] r, r_next;
  logic [DVS_W-1:0] d;
  logic             neg;
  logic             busy;
  logic [CW-1:0]    cnt;

  always_comb begin
    logic [DVS_W:0] rr;
    n_next = n;
    r_next = r;
    for (int i = 0; i < 2; i++) begin
      rr = {r_next, n_next[DVD_W-1]};
      n_next = {n_next[DVD_W-2:0], 1'b0};
      if (rr >= {1'b0, d}) begin
        rr = rr - {1'b0, d};
        n_next[0] = 1'b1;
      end
      r_next = rr[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n    <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        neg  <= dividend[DVD_W-1];
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        n <= n_next;
        r <= r_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(n) : $signed(n);

endmodule

FILE: hw/rtl/cbc_ctrl.sv
// sequencer of the balance controller: handshakes and step order
module cbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cbc_pkg::sts_t  sts,
  output cbc_pkg::cmd_t  cmd
);
  import cbc_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;
  logic   fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      out_valid <= fin | (out_valid & ~out_ready);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NOP;
    fin        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_CMD;
        end
      end
      S_CMD:     begin cmd.op = OP_DIV_CMD; state_next = S_WAIT; ret_next = S_RAMP;   end
      S_RAMP:    begin cmd.op = OP_RAMP;    state_next = S_MUL_SI;                    end
      S_MUL_SI:  begin cmd.op = OP_MUL_SI;  state_next = S_DIV_SI;                    end
      S_DIV_SI:  begin cmd.op = OP_DIV_SI;  state_next = S_WAIT; ret_next = S_PINT;   end
      S_PINT:    begin cmd.op = OP_PINT;    state_next = S_DIV_SP;                    end
      S_DIV_SP:  begin cmd.op = OP_DIV_SP;  state_next = S_WAIT; ret_next = S_PE;     end
      S_PE:      begin cmd.op = OP_PE;      state_next = S_MUL_PP;                    end
      S_MUL_PP:  begin cmd.op = OP_MUL_PP;  state_next = S_T1A;                       end
      S_T1A:     begin cmd.op = OP_T1A;     state_next = S_T1B;                       end
      S_T1B:     begin cmd.op = OP_T1B;     state_next = S_DIV_FD;                    end
      S_DIV_FD:  begin cmd.op = OP_DIV_FD;  state_next = S_WAIT; ret_next = S_SCN1;   end
      S_SCN1:    begin cmd.op = OP_DIV_SCN; state_next = S_WAIT; ret_next = S_T1_SAVE; end
      S_T1_SAVE: begin cmd.op = OP_T1_SAVE; state_next = S_MUL_RI;                    end
      S_MUL_RI:  begin cmd.op = OP_MUL_RI;  state_next = S_DIV_RI;                    end
      S_DIV_RI:  begin cmd.op = OP_DIV_RI;  state_next = S_WAIT; ret_next = S_RINT;   end
      S_RINT:    begin cmd.op = OP_RINT;    state_next = S_DIV_R20;                   end
      S_DIV_R20: begin cmd.op = OP_DIV_R20; state_next = S_WAIT; ret_next = S_RE;     end
      S_RE:      begin cmd.op = OP_RE;      state_next = S_MUL_RP;                    end
      S_MUL_RP:  begin cmd.op = OP_MUL_RP;  state_next = S_T2A;                       end
      S_T2A:     begin cmd.op = OP_T2A;     state_next = S_DIV_RD;                    end
      S_DIV_RD:  begin cmd.op = OP_DIV_RD;  state_next = S_WAIT; ret_next = S_T2B;    end
      S_T2B:     begin cmd.op = OP_T2B;     state_next = S_DIV_FR;                    end
      S_DIV_FR:  begin cmd.op = OP_DIV_FR;  state_next = S_WAIT; ret_next = S_SCN2;   end
      S_SCN2:    begin cmd.op = OP_DIV_SCN; state_next = S_WAIT; ret_next = S_FIN;    end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op = OP_FIN;
          fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (sts.div_done) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/cbc_dp.sv
// datapath: loop state, gain registers, shared multiplier and divider
module cbc_dp #(
  parameter int FILTER_SHIFT = cbc_pkg::FILTER_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cbc_pkg::cmd_t      cmd,
  output cbc_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               joystick_enabled,
  input  logic [7:0]         joystick_y,
  input  logic signed [15:0] drive_speed,
  input  logic signed [15:0] roll_wheel_speed,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  output logic signed [15:0] drive_torque,
  output logic signed [15:0] roll_torque,
  output logic               active
);
  import cbc_pkg::*;

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic wide_t tdiv256(input wide_t v);
    wide_t b;
    b = v[DVD_W-1] ? wide_t'(255) : wide_t'(0);
    return (v + b) >>> 8;
  endfunction

  function automatic logic signed [15:0] out16(input wide_t v);
    wide_t s;
    s = v >>> 8;
    if (s > wide_t'(32767)) return 16'sh7FFF;
    if (s < wide_t'(-32768)) return 16'sh8000;
    return 16'(s);
  endfunction

  function automatic wide_t absw(input wide_t v);
    return v[DVD_W-1] ? -v : v;
  endfunction

  // gain and trim registers
  logic [15:0]        speed_i_gain, speed_p_gain, pitch_p_gain, pitch_d_gain;
  logic [15:0]        roll_speed_i_gain, roll_p_gain;
  logic signed [15:0] pitch_trim, roll_trim;

  // latched input word
  logic               joy_en_r;
  logic [7:0]         joy_y_r;
  logic signed [15:0] dspd_r, rspd_r, pitch_r, roll_r;

  // loop state
  logic signed [31:0] target, dsf, rsf, pint, rint, lpe, lre;
  logic               engaged;

  // working registers
  logic signed [31:0]      err_r;
  logic signed [ACC_W-1:0] acc, t1;
  logic signed [P_W-1:0]   p;

  // multiplier and divider hookup
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic                    mul_en;
  logic                    div_start;
  wide_t                   div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic                    div_done;
  wide_t                   q;

  cbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (q)
  );

  assign sts.div_done = div_done;

  // widened views
  wide_t tgt_w, dsf_w, rsf_w, pint_w, rint_w, err_w, lpe_w, lre_w, acc_w, t1_w, p_w;
  wide_t dspd_w, rspd_w, pitch_w, roll_w, ptrim_w, rtrim_w;
  logic signed [8:0] jd;
  wide_t cmd_dvd, sc_d, acc_cl, lim;
  logic signed [31:0] tgt_nx, dsf_nx, rsf_nx;
  logic signed [16:0] roll_dev;
  logic               eng_n;

  assign tgt_w   = wide_t'(target);
  assign dsf_w   = wide_t'(dsf);
  assign rsf_w   = wide_t'(rsf);
  assign pint_w  = wide_t'(pint);
  assign rint_w  = wide_t'(rint);
  assign err_w   = wide_t'(err_r);
  assign lpe_w   = wide_t'(lpe);
  assign lre_w   = wide_t'(lre);
  assign acc_w   = wide_t'(acc);
  assign t1_w    = wide_t'(t1);
  assign p_w     = wide_t'(p);
  assign dspd_w  = wide_t'(dspd_r) <<< 8;
  assign rspd_w  = wide_t'(rspd_r) <<< 8;
  assign pitch_w = wide_t'(pitch_r) <<< 8;
  assign roll_w  = wide_t'(roll_r) <<< 8;
  assign ptrim_w = wide_t'(pitch_trim) <<< 8;
  assign rtrim_w = wide_t'(roll_trim) <<< 8;

  // joystick command numerator 5*65536*(127-y)
  assign jd      = 9'sd127 - $signed({1'b0, joy_y_r});
  assign cmd_dvd = joy_en_r ? ((wide_t'(jd) * wide_t'(5)) <<< 16) : wide_t'(0);

  assign tgt_nx = (q > tgt_w) ? sat32(tgt_w + wide_t'(164)) :
                  (q < tgt_w) ? sat32(tgt_w - wide_t'(164)) : target;
  assign dsf_nx = sat32(dsf_w + ((dspd_w - dsf_w) >>> FILTER_SHIFT));
  assign rsf_nx = sat32(rsf_w + ((rspd_w - rsf_w) >>> FILTER_SHIFT));

  // scale denominator from |f|/40 and the clamped torque
  always_comb begin
    sc_d = wide_t'(65536) - q;
    if (sc_d < wide_t'(16384)) sc_d = wide_t'(16384);
    if (sc_d > wide_t'(65536)) sc_d = wide_t'(65536);
    lim = wide_t'(1) <<< 40;
    acc_cl = acc_w;
    if (acc_cl > lim) acc_cl = lim;
    if (acc_cl < -lim) acc_cl = -lim;
  end

  // activation, q holds the scaled roll torque at the final step
  assign roll_dev = 17'(roll_r) - 17'(roll_trim);
  always_comb begin
    eng_n = engaged | ((q < wide_t'(3277)) && (q > wide_t'(-3277)));
    if (roll_dev > 17'sd2560 || roll_dev < -17'sd2560) eng_n = 1'b0;
    if (pitch_r > 16'sd11520 || pitch_r < -16'sd11520) eng_n = 1'b0;
  end

  // operand selection for the shared units
  always_comb begin
    div_start = 1'b0;
    div_dvd   = wide_t'(0);
    div_dvs   = DVS_W'(1);
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (cmd.op)
      OP_DIV_CMD: begin div_start = 1'b1; div_dvd = cmd_dvd; div_dvs = DVS_W'(127); end
      OP_DIV_SI:  begin div_start = 1'b1; div_dvd = p_w; div_dvs = DVS_W'(25600); end
      OP_DIV_SP:  begin div_start = 1'b1; div_dvd = p_w; div_dvs = DVS_W'(2560); end
      OP_DIV_FD:  begin div_start = 1'b1; div_dvd = absw(dsf_w); div_dvs = DVS_W'(40); end
      OP_DIV_FR:  begin div_start = 1'b1; div_dvd = absw(rsf_w); div_dvs = DVS_W'(40); end
      OP_DIV_SCN: begin div_start = 1'b1; div_dvd = acc_cl <<< 16; div_dvs = DVS_W'(sc_d); end
      OP_DIV_RI:  begin div_start = 1'b1; div_dvd = p_w; div_dvs = DVS_W'(128000000); end
      OP_DIV_R20: begin div_start = 1'b1; div_dvd = rsf_w; div_dvs = DVS_W'(20); end
      OP_DIV_RD: begin
        div_start = 1'b1;
        div_dvd   = (err_w - lre_w) <<< 1;
        div_dvs   = DVS_W'(5);
      end
      OP_MUL_SI: begin
        mul_en = 1'b1; mul_a = MA_W'(tgt_w - dspd_w); mul_b = {1'b0, speed_i_gain};
      end
      OP_PINT: begin
        mul_en = 1'b1; mul_a = MA_W'(tgt_w - dsf_w); mul_b = {1'b0, speed_p_gain};
      end
      OP_MUL_PP: begin
        mul_en = 1'b1; mul_a = MA_W'(err_w); mul_b = {1'b0, pitch_p_gain};
      end
      OP_T1A: begin
        mul_en = 1'b1; mul_a = MA_W'(err_w - lpe_w); mul_b = {1'b0, pitch_d_gain};
      end
      OP_MUL_RI: begin
        mul_en = 1'b1; mul_a = MA_W'(rsf_w); mul_b = {1'b0, roll_speed_i_gain};
      end
      OP_MUL_RP: begin
        mul_en = 1'b1; mul_a = MA_W'(err_w); mul_b = {1'b0, roll_p_gain};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= P_W'(wide_t'(mul_a) * wide_t'(mul_b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_i_gain      <= RST_SPEED_I_GAIN;
      speed_p_gain      <= RST_SPEED_P_GAIN;
      pitch_p_gain      <= RST_PITCH_P_GAIN;
      pitch_d_gain      <= RST_PITCH_D_GAIN;
      pitch_trim        <= RST_PITCH_TRIM;
      roll_speed_i_gain <= RST_ROLL_SPEED_I_GAIN;
      roll_p_gain       <= RST_ROLL_P_GAIN;
      roll_trim         <= RST_ROLL_TRIM;
      target  <= '0;
      dsf     <= '0;
      rsf     <= '0;
      pint    <= '0;
      rint    <= '0;
      lpe     <= '0;
      lre     <= '0;
      engaged <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SPEED_I_GAIN:      speed_i_gain      <= cfg_data;
          CFG_SPEED_P_GAIN:      speed_p_gain      <= cfg_data;
          CFG_PITCH_P_GAIN:      pitch_p_gain      <= cfg_data;
          CFG_PITCH_D_GAIN:      pitch_d_gain      <= cfg_data;
          CFG_PITCH_TRIM:        pitch_trim        <= cfg_data;
          CFG_ROLL_SPEED_I_GAIN: roll_speed_i_gain <= cfg_data;
          CFG_ROLL_P_GAIN:       roll_p_gain       <= cfg_data;
          CFG_ROLL_TRIM:         roll_trim         <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_RAMP: begin
          target <= tgt_nx;
          dsf    <= dsf_nx;
          rsf    <= rsf_nx;
        end
        OP_DIV_SI: ;
        OP_PINT:  pint <= sat32(pint_w + q);
        OP_RINT:  rint <= sat32(rint_w + q);
        OP_T1B:   lpe  <= err_r;
        OP_T2B:   lre  <= err_r;
        OP_FIN: begin
          engaged <= eng_n;
          if (!eng_n) begin
            pint <= '0;
            rint <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        joy_en_r <= joystick_enabled;
        joy_y_r  <= joystick_y;
        dspd_r   <= drive_speed;
        rspd_r   <= roll_wheel_speed;
        pitch_r  <= pitch_angle;
        roll_r   <= roll_angle;
      end
      OP_PE:      err_r <= sat32(ptrim_w + pint_w + q - pitch_w);
      OP_RE:      err_r <= sat32(rtrim_w + rint_w + q - roll_w);
      OP_T1A:     acc <= ACC_W'(tdiv256(p_w));
      OP_T1B:     acc <= ACC_W'(acc_w - tdiv256(p_w));
      OP_T2A:     acc <= ACC_W'(-tdiv256(p_w));
      OP_T2B:     acc <= ACC_W'(acc_w + q);
      OP_T1_SAVE: t1  <= ACC_W'(q);
      OP_FIN: begin
        drive_torque <= eng_n ? out16(t1_w) : 16'sd0;
        roll_torque  <= eng_n ? out16(q) : 16'sd0;
        active       <= eng_n;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/cascaded_balance_controller.sv
// top level of the cascaded pitch and roll balance controller
//
// one input word is one control tick: joystick, both wheel speeds and the
// pitch and roll angles; one output word per tick carries the drive and
// roll torque commands and the engaged flag
// channels: in_valid/in_ready and out_valid/out_ready, a word moves when
// valid and ready are both high; cfg_valid/cfg_ready writes gain or trim
// register cfg_index with cfg_data, cfg_ready is always high
// timing: the shared radix-4 divider sets the time from the accepting edge of
// an input word to out_valid: ten divisions per tick, each waited out until
// its done, plus the other sequencer steps
// one tick at a time: the next input word is taken once the previous result
// sits in the output register
// stall: while the receiver holds out_ready low the finished word waits in
// the output register; the next tick is still taken and computed and then
// waits at its final step
// reset: gains and trims return to their defaults, all loop state clears
// and the controller starts disengaged
module cascaded_balance_controller #(
  parameter int FILTER_SHIFT = cbc_pkg::FILTER_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               joystick_enabled,
  input  logic [7:0]         joystick_y,
  input  logic signed [15:0] drive_speed,
  input  logic signed [15:0] roll_wheel_speed,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] drive_torque,
  output logic signed [15:0] roll_torque,
  output logic               active
);
  import cbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers may be written at any time the block is idle
  assign cfg_ready = 1'b1;

  // sequencer: handshakes and step order
  cbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, loop state and output register
  cbc_dp #(
    .FILTER_SHIFT (FILTER_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .joystick_enabled (joystick_enabled),
    .joystick_y       (joystick_y),
    .drive_speed      (drive_speed),
    .roll_wheel_speed (roll_wheel_speed),
    .pitch_angle      (pitch_angle),
    .roll_angle       (roll_angle),
    .drive_torque     (drive_torque),
    .roll_torque      (roll_torque),
    .active           (active)
  );

endmodule

FILE: hw/rtl/cbc_checker.sv
// port-level checks of the balance controller, bound to the top level
module cbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] drive_torque,
  input logic signed [15:0] roll_torque,
  input logic               active
);

  // a waiting output word is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a disengaged controller drives no torque
  a_idle_torque: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> drive_torque == 16'sd0 && roll_torque == 16'sd0)
    else $error("torque while disengaged");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while a tick is in work");

endmodule

bind cascaded_balance_controller cbc_checker u_cbc_checker (.*);

FILE: verif/cbc_checker.sv
// torque predictor and output comparison for the cascaded balance controller
module cbc_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               joystick_enabled,
  input  logic [7:0]         joystick_y,
  input  logic signed [15:0] drive_speed,
  input  logic signed [15:0] roll_wheel_speed,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] drive_torque,
  input  logic signed [15:0] roll_torque,
  input  logic               active,
  output int                 fail_count,
  output int                 pending_count,
  output int                 checked_count,
  output int                 engaged_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  localparam int FSHIFT = FILTER_SHIFT_DEF;

  typedef struct {
    logic signed [15:0] drive;
    logic signed [15:0] roll;
    logic               act;
  } torque_word_t;

  torque_word_t torque_q[$];

  logic [15:0] k_si, k_sp, k_pp, k_pd, k_rsi, k_rp;
  longint      trim_p, trim_r;
  int          tgt_spd, dsf, rsf, p_int, r_int, last_pe, last_re;
  logic        engaged_q;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint speed_scaled(longint t, int f);
    longint a, d;
    a = f < 0 ? -longint'(f) : longint'(f);
    d = clip(65536 - a / 40, 16384, 65536);
    t = clip(t, -(64'sd1 <<< 40), 64'sd1 <<< 40);
    return (t * 65536) / d;
  endfunction

  function automatic logic signed [15:0] to_q88(longint t);
    return 16'(clip(t >>> 8, -32768, 32767));
  endfunction

  function automatic torque_word_t predict_tick();
    torque_word_t w;
    longint cmd, dev, tp, pe, t1, tr, re, t2, diff, dspd, rspd, pq, rq, rd;
    dspd = longint'(drive_speed) * 256;
    rspd = longint'(roll_wheel_speed) * 256;
    pq = longint'(pitch_angle);
    rq = longint'(roll_angle);
    cmd = 0;
    if (joystick_enabled) cmd = (5 * 65536 * (127 - longint'(joystick_y))) / 127;
    if (cmd > tgt_spd) tgt_spd = sat32(longint'(tgt_spd) + 164);
    else if (cmd < tgt_spd) tgt_spd = sat32(longint'(tgt_spd) - 164);
    // pitch cascade
    dsf = sat32(longint'(dsf) + ((dspd - dsf) >>> FSHIFT));
    dev = longint'(tgt_spd) - dspd;
    p_int = sat32(longint'(p_int) + (dev * longint'(k_si)) / 25600);
    dev = longint'(tgt_spd) - dsf;
    tp = longint'(p_int) + (dev * longint'(k_sp)) / 2560;
    pe = sat32(trim_p * 256 + tp - pq * 256);
    diff = pe - last_pe;
    t1 = (pe * longint'(k_pp)) / 256 - (diff * longint'(k_pd)) / 256;
    t1 = speed_scaled(t1, dsf);
    last_pe = int'(pe);
    // roll cascade
    rsf = sat32(longint'(rsf) + ((rspd - rsf) >>> FSHIFT));
    r_int = sat32(longint'(r_int) + (longint'(rsf) * longint'(k_rsi)) / 128000000);
    tr = longint'(r_int) + longint'(rsf) / 20;
    re = sat32(trim_r * 256 + tr - rq * 256);
    diff = re - last_re;
    t2 = -(re * longint'(k_rp)) / 256 + (diff * 2) / 5;
    t2 = speed_scaled(t2, rsf);
    last_re = int'(re);
    // activation with hysteresis and cutoffs
    if (!engaged_q && t2 < 3277 && t2 > -3277) engaged_q = 1'b1;
    rd = rq - trim_r;
    if (rd > 2560 || rd < -2560) engaged_q = 1'b0;
    if (pq > 11520 || pq < -11520) engaged_q = 1'b0;
    if (!engaged_q) begin
      t1 = 0;
      t2 = 0;
      p_int = 0;
      r_int = 0;
    end
    w.drive = to_q88(t1);
    w.roll = to_q88(t2);
    w.act = engaged_q;
    return w;
  endfunction

  assign pending_count = torque_q.size();

  always @(posedge clk) begin
    torque_word_t exp_w;
    if (rst) begin
      k_si <= RST_SPEED_I_GAIN;
      k_sp <= RST_SPEED_P_GAIN;
      k_pp <= RST_PITCH_P_GAIN;
      k_pd <= RST_PITCH_D_GAIN;
      trim_p = longint'(signed'(RST_PITCH_TRIM));
      k_rsi <= RST_ROLL_SPEED_I_GAIN;
      k_rp <= RST_ROLL_P_GAIN;
      trim_r = longint'(signed'(RST_ROLL_TRIM));
      tgt_spd = 0; dsf = 0; rsf = 0; p_int = 0; r_int = 0;
      last_pe = 0; last_re = 0; engaged_q = 1'b0;
      torque_q.delete();
      fail_count <= 0;
      checked_count <= 0;
      engaged_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (torque_q.size() == 0) begin
          $error("unexpected output word: drive %0d roll %0d", drive_torque, roll_torque);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = torque_q.pop_front();
          checked_count <= checked_count + 1;
          if (active) engaged_count <= engaged_count + 1;
          if (drive_torque !== exp_w.drive || roll_torque !== exp_w.roll ||
              active !== exp_w.act) begin
            fail_count <= fail_count + 1;
            if (drive_torque !== exp_w.drive)
              $error("drive_torque expected %0d actual %0d", exp_w.drive, drive_torque);
            if (roll_torque !== exp_w.roll)
              $error("roll_torque expected %0d actual %0d", exp_w.roll, roll_torque);
            if (active !== exp_w.act)
              $error("active expected %0b actual %0b", exp_w.act, active);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPEED_I_GAIN:      k_si <= cfg_data;
          CFG_SPEED_P_GAIN:      k_sp <= cfg_data;
          CFG_PITCH_P_GAIN:      k_pp <= cfg_data;
          CFG_PITCH_D_GAIN:      k_pd <= cfg_data;
          CFG_PITCH_TRIM:        trim_p = longint'(signed'(cfg_data));
          CFG_ROLL_SPEED_I_GAIN: k_rsi <= cfg_data;
          CFG_ROLL_P_GAIN:       k_rp <= cfg_data;
          CFG_ROLL_TRIM:         trim_r = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) torque_q.push_back(predict_tick());
    end
  end

endmodule

FILE: verif/tb_cascaded_balance_controller.sv
// testbench top: stimulus, register phases and verdict for the balance controller
module tb_cascaded_balance_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  // cap on the run, several times the slowest expected run
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS  = 320;

  typedef struct {
    logic        joy_en;
    logic [7:0]  joy_y;
    logic [15:0] dspd;
    logic [15:0] rspd;
    logic [15:0] pitch;
    logic [15:0] roll;
  } tick_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               joystick_enabled = 1'b0;
  logic [7:0]         joystick_y = '0;
  logic signed [15:0] drive_speed = '0;
  logic signed [15:0] roll_wheel_speed = '0;
  logic signed [15:0] pitch_angle = '0;
  logic signed [15:0] roll_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] drive_torque;
  logic signed [15:0] roll_torque;
  logic               active;

  int fail_count, pending_count, checked_count, engaged_count;
  int cycle_count = 0;
  int sent_count = 0;
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_idle = 0;   // percent of cycles the receiver stalls
  int roll_trim_now = -947;  // mirror of the roll trim, used to aim the stimulus

  cascaded_balance_controller u_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .joystick_enabled, .joystick_y, .drive_speed,
    .roll_wheel_speed, .pitch_angle, .roll_angle,
    .out_valid, .out_ready, .drive_torque, .roll_torque, .active
  );

  cbc_scoreboard u_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .joystick_enabled, .joystick_y, .drive_speed,
    .roll_wheel_speed, .pitch_angle, .roll_angle,
    .out_valid, .out_ready, .drive_torque, .roll_torque, .active,
    .fail_count, .pending_count, .checked_count, .engaged_count
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver backpressure, one decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // one word on the input channel; valid stays high across back-to-back words
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    joystick_enabled <= t.joy_en;
    joystick_y       <= t.joy_y;
    drive_speed      <= t.dspd;
    roll_wheel_speed <= t.rspd;
    pitch_angle      <= t.pitch;
    roll_angle       <= t.roll;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROLL_TRIM) roll_trim_now = int'(signed'(val));
    @(posedge clk);
  endtask

  // drop valid and let every outstanding word come back
  task automatic drain();
    in_valid <= 1'b0;
    // wait for the next edge so the last accepted word is already counted as pending
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] clamp16(int v);
    return 16'(v > 32767 ? 32767 : (v < -32768 ? -32768 : v));
  endfunction

  // 75% balanced rider near the roll working point, 10% near cutoffs, 15% raw noise
  function automatic tick_t rand_tick();
    tick_t t;
    int sel;
    sel = $urandom_range(99);
    t.joy_en = 1'($urandom_range(1));
    t.joy_y  = 8'($urandom_range(255));
    if (sel < 75) begin
      t.dspd  = clamp16($urandom_range(2048) - 1024);
      t.rspd  = clamp16($urandom_range(128) - 64);
      t.pitch = clamp16($urandom_range(6000) - 3000);
      t.roll  = clamp16(roll_trim_now + $urandom_range(4) - 2);
    end else if (sel < 85) begin
      // near the cutoffs
      t.dspd  = clamp16($urandom_range(512) - 256);
      t.rspd  = clamp16($urandom_range(64) - 32);
      t.pitch = clamp16(($urandom_range(1) ? 11520 : -11520) + $urandom_range(2) - 1);
      t.roll  = clamp16(roll_trim_now + ($urandom_range(1) ? 2560 : -2560)
                        + $urandom_range(2) - 1);
    end else begin
      t.dspd  = 16'($urandom);
      t.rspd  = 16'($urandom);
      t.pitch = 16'($urandom);
      t.roll  = 16'($urandom);
    end
    return t;
  endfunction

  task automatic directed_ticks();
    tick_t t;
    // engage from rest at the roll working point
    t = '{1'b0, 8'd127, 16'd0, 16'd0, 16'd0, 16'hFC4D};
    repeat (3) send_tick(t);
    // joystick extremes and centered
    t.joy_en = 1'b1;
    t.joy_y = 8'd0;   repeat (2) send_tick(t);
    t.joy_y = 8'd255; repeat (2) send_tick(t);
    t.joy_y = 8'd127; send_tick(t);
    // pitch cutoff on both sides, and just inside
    t.pitch = 16'sd11521;  send_tick(t);
    t.pitch = -16'sd11521; send_tick(t);
    t.pitch = 16'sd11520;  send_tick(t);
    t.pitch = 16'd0;
    // roll cutoff on both sides
    t.roll = clamp16(-947 + 2561); send_tick(t);
    t.roll = clamp16(-947 - 2561); send_tick(t);
    t.roll = clamp16(-947 + 2560); send_tick(t);
    // field extremes
    t = '{1'b1, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}; send_tick(t);
    t = '{1'b0, 8'd255, 16'h8000, 16'h8000, 16'h8000, 16'h8000}; send_tick(t);
    t = '{1'b1, 8'd255, 16'h7FFF, 16'h8000, 16'h0000, 16'hFC4D}; send_tick(t);
    t = '{1'b1, 8'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFC4D}; send_tick(t);
    t = '{1'b0, 8'h55, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; send_tick(t);
  endtask

  task automatic random_ticks(int n);
    repeat (n) send_tick(rand_tick());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: moderate gains, sender idles lightly, receiver heavily
    send_idle = 18;
    recv_idle = 49;
    write_reg(CFG_SPEED_I_GAIN, 16'd300);
    write_reg(CFG_SPEED_P_GAIN, 16'd2000);
    write_reg(CFG_PITCH_P_GAIN, 16'd600);
    write_reg(CFG_PITCH_D_GAIN, 16'd200);
    write_reg(CFG_PITCH_TRIM, 16'd1408);
    write_reg(CFG_ROLL_SPEED_I_GAIN, 16'd5120);
    write_reg(CFG_ROLL_P_GAIN, 16'd768);
    write_reg(CFG_ROLL_TRIM, 16'hFC4D);
    directed_ticks();
    random_ticks(RAND_ITEMS);
    drain();

    // phase 2: every gain at full scale, trims at the top, idling swapped
    send_idle = 49;
    recv_idle = 18;
    write_reg(CFG_SPEED_I_GAIN, 16'hFFFF);
    write_reg(CFG_SPEED_P_GAIN, 16'hFFFF);
    write_reg(CFG_PITCH_P_GAIN, 16'hFFFF);
    write_reg(CFG_PITCH_D_GAIN, 16'hFFFF);
    write_reg(CFG_PITCH_TRIM, 16'h7FFF);
    write_reg(CFG_ROLL_SPEED_I_GAIN, 16'hFFFF);
    write_reg(CFG_ROLL_P_GAIN, 16'hFFFF);
    write_reg(CFG_ROLL_TRIM, 16'h7FFF);
    random_ticks(RAND_ITEMS);
    drain();

    // phase 3: zero gains, trims at the bottom, no idling
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_SPEED_I_GAIN, 16'h0000);
    write_reg(CFG_SPEED_P_GAIN, 16'h0000);
    write_reg(CFG_PITCH_P_GAIN, 16'h0000);
    write_reg(CFG_PITCH_D_GAIN, 16'h0000);
    write_reg(CFG_PITCH_TRIM, 16'h8000);
    write_reg(CFG_ROLL_SPEED_I_GAIN, 16'h0000);
    write_reg(CFG_ROLL_P_GAIN, 16'h0000);
    write_reg(CFG_ROLL_TRIM, 16'h8000);
    random_ticks(RAND_ITEMS);
    drain();

    // phase 4: back to the default tuning, random gains on the speed loop
    write_reg(CFG_SPEED_I_GAIN, 16'($urandom));
    write_reg(CFG_SPEED_P_GAIN, 16'($urandom_range(4096)));
    write_reg(CFG_PITCH_P_GAIN, RST_PITCH_P_GAIN);
    write_reg(CFG_PITCH_D_GAIN, RST_PITCH_D_GAIN);
    write_reg(CFG_PITCH_TRIM, RST_PITCH_TRIM);
    write_reg(CFG_ROLL_SPEED_I_GAIN, RST_ROLL_SPEED_I_GAIN);
    write_reg(CFG_ROLL_P_GAIN, RST_ROLL_P_GAIN);
    write_reg(CFG_ROLL_TRIM, RST_ROLL_TRIM);
    random_ticks(RAND_ITEMS);

    // final drain followed by quiet cycles before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("run covered %0d control ticks over four register settings", sent_count);
    $display("%0d output words checked, %0d of them engaged", checked_count, engaged_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
